/* hdl/wrmf_pkg.sv */
// Shared types and constants of the RGB window rank/mean filter.
// Used by every module of the filter; depends on nothing else.
package wrmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIN_SIDE   = 3;
    localparam int WIN_AREA   = WIN_SIDE * WIN_SIDE;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SUM_W      = 12;
    localparam int RECIP_W    = 13;
    // floor(sum / 9) == (sum * 7282) >> 16 for every sum up to 9 * 255.
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic [1:0] MODE_MAX    = 2'd0;
    localparam logic [1:0] MODE_MEAN   = 2'd1;
    localparam logic [1:0] MODE_MEDIAN = 2'd2;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out_item;

    // One stage of the sorting chain: three channels of nine samples.
    typedef struct packed {
        logic                               valid;
        logic                               frame_end;
        logic [2:0][SUM_W-1:0]              sum;
        logic [2:0][WIN_AREA-1:0][7:0]      v;
    } t_stage;

endpackage

/* hdl/wrmf_line_store.sv */
// Line store: one bank per window row, each with one write and two read ports.
// Read data is registered; a read of the entry written at the same edge sees the new pixel.
// Depends on wrmf_pkg.
module wrmf_line_store (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [1:0]                        i_wbank,
    input  logic [wrmf_pkg::COL_W-1:0]        i_waddr,
    input  logic [23:0]                       i_wdata,
    input  logic                              i_re,
    input  logic [wrmf_pkg::COL_W-1:0]        i_addr_a,
    input  logic [wrmf_pkg::COL_W-1:0]        i_addr_b,
    output logic [wrmf_pkg::WIN_SIDE-1:0][23:0] o_rd_a,
    output logic [wrmf_pkg::WIN_SIDE-1:0][23:0] o_rd_b
);
    import wrmf_pkg::*;

    for (genvar b = 0; b < WIN_SIDE; b++) begin : g_bank
        logic [23:0] mem [MAX_WIDTH];
        logic        wr_here;

        assign wr_here = i_we && (i_wbank == 2'(b));

        always_ff @(posedge i_clk) begin
            if (wr_here) begin
                mem[i_waddr] <= i_wdata;
            end
            if (i_re) begin
                o_rd_a[b] <= (wr_here && i_waddr == i_addr_a) ? i_wdata : mem[i_addr_a];
                o_rd_b[b] <= (wr_here && i_waddr == i_addr_b) ? i_wdata : mem[i_addr_b];
            end
        end
    end

endmodule

/* hdl/wrmf_sort_cell.sv */
// One cell of the odd-even transposition chain: a layer of compare-exchange per channel.
// Cells alternate between even and odd pairs. Depends on wrmf_pkg.
module wrmf_sort_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_odd,
    input  wrmf_pkg::t_stage i_data,
    output wrmf_pkg::t_stage o_data
);
    import wrmf_pkg::*;

    t_stage n_data;
    t_stage r_data;

    always_comb begin
        n_data = i_data;
        for (int ch = 0; ch < 3; ch++) begin
            for (int p = 0; p < (WIN_AREA - 1) / 2; p++) begin
                int lo;
                lo = i_odd ? 2 * p + 1 : 2 * p;
                if (i_data.v[ch][lo] > i_data.v[ch][lo + 1]) begin
                    n_data.v[ch][lo]     = i_data.v[ch][lo + 1];
                    n_data.v[ch][lo + 1] = i_data.v[ch][lo];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else if (i_en) begin
            r_data.valid <= n_data.valid;
        end
        if (i_en) begin
            r_data.frame_end <= n_data.frame_end;
            r_data.sum       <= n_data.sum;
            r_data.v         <= n_data.v;
        end
    end

    assign o_data = r_data;

endmodule

/* hdl/window_rank_mean_filter_rgb_unit.sv */
// RGB 3x3 window filter (max, mean or median per channel) over a raster stream.
// Throughput: one item per cycle while the output is not stalled.
// Results pass the read stage, window register, sort cells and output register. A result is
// ready RADIUS rows plus RADIUS pixels after its own input pixel, or through flush items.
// Reset is synchronous: positions clear, registers take their reset values, the line store
// keeps its contents. Depends on wrmf_pkg, wrmf_line_store and wrmf_sort_cell.
module window_rank_mean_filter_rgb_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  wrmf_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output wrmf_pkg::t_out_item o_out_item,
    input  logic                i_out_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import wrmf_pkg::*;

    // Configuration registers.
    logic [10:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [1:0]  r_filter_mode;
    logic        cfg_wr;
    logic        geo_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign geo_wr = cfg_wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd1024;
            r_frame_height <= 13'd1;
            r_filter_mode  <= MODE_MAX;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_frame_width  <= pwdata[10:0];
                REG_HEIGHT: r_frame_height <= pwdata[12:0];
                REG_MODE:   r_filter_mode  <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {21'd0, r_frame_width};
            REG_HEIGHT: prdata = {19'd0, r_frame_height};
            REG_MODE:   prdata = {30'd0, r_filter_mode};
            default:    prdata = 32'd0;
        endcase
    end

    logic [10:0] w;
    logic [12:0] h;

    always_comb begin
        if (r_frame_width == 11'd0)                 w = 11'd1;
        else if (r_frame_width > 11'(MAX_WIDTH))    w = 11'(MAX_WIDTH);
        else                                        w = r_frame_width;
        if (r_frame_height == 13'd0)                h = 13'd1;
        else if (r_frame_height > 13'(MAX_HEIGHT))  h = 13'(MAX_HEIGHT);
        else                                        h = r_frame_height;
    end

    // Pipeline advances whenever the output register is free or being taken.
    logic en;
    logic accept;

    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    // Frame positions.
    logic [COL_W-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [1:0]       r_in_bank, n_in_bank, r_out_bank, n_out_bank;
    logic             r_done, n_done;
    logic             take_px, ready, emit, last_col, last_row;
    logic [12:0]      rr;
    logic [10:0]      cc;
    logic [10:0]      col_next;
    logic [12:0]      row_next;

    assign take_px  = accept && !i_in_item.flush && !r_done;
    assign col_next = {1'b0, r_out_col} + 11'd1;
    assign row_next = {1'b0, r_out_row} + 13'd1;
    assign last_col = col_next >= w;
    assign last_row = row_next >= h;
    assign rr       = (row_next > h - 13'd1) ? h - 13'd1 : row_next;
    assign cc       = (col_next > w - 11'd1) ? w - 11'd1 : col_next;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_bank = r_in_bank;
        n_done    = r_done;
        if (take_px) begin
            if ({1'b0, r_in_col} + 11'd1 >= w) begin
                n_in_col  = '0;
                n_in_bank = (r_in_bank == 2'd2) ? 2'd0 : r_in_bank + 2'd1;
                if ({1'b0, r_in_row} + 13'd1 >= h) begin
                    n_in_row  = '0;
                    n_in_bank = 2'd0;
                    n_done    = 1'b1;
                end else begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end
        // Received count beats the needed index; compared as (row, column) pairs.
        ready = n_done || ({1'b0, n_in_row} > rr) ||
                ({1'b0, n_in_row} == rr && {1'b0, n_in_col} > cc);
        emit  = accept && ready;

        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_bank = r_out_bank;
        if (emit) begin
            if (last_col) begin
                n_out_col  = '0;
                n_out_row  = r_out_row + 1'b1;
                n_out_bank = (r_out_bank == 2'd2) ? 2'd0 : r_out_bank + 2'd1;
                if (last_row) begin
                    n_out_row  = '0;
                    n_out_bank = 2'd0;
                    n_in_col   = '0;
                    n_in_row   = '0;
                    n_in_bank  = 2'd0;
                    n_done     = 1'b0;
                end
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geo_wr) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_bank  <= 2'd0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_bank <= 2'd0;
            r_done     <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_bank  <= n_in_bank;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_bank <= n_out_bank;
            r_done     <= n_done;
        end
    end

    // Line store.
    logic [WIN_SIDE-1:0][23:0] rd_a, rd_b;

    wrmf_line_store u_store (
        .i_clk    (i_clk),
        .i_we     (take_px),
        .i_wbank  (r_in_bank),
        .i_waddr  (r_in_col),
        .i_wdata  ({i_in_item.in_red, i_in_item.in_green, i_in_item.in_blue}),
        .i_re     (accept),
        .i_addr_a (r_out_col),
        .i_addr_b (col_next[COL_W-1:0]),
        .o_rd_a   (rd_a),
        .o_rd_b   (rd_b)
    );

    // Stage 1: read data arrives; geometry of the window travels alongside.
    logic       r_s1_valid;
    logic       r_s1_end;
    logic [2:0] r_s1_row_z;
    logic       r_s1_left_z;
    logic       r_s1_right_z;
    logic [2:0][1:0] r_s1_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= emit;
        end
        if (accept) begin
            r_s1_end     <= last_col && last_row;
            r_s1_row_z   <= {last_row, 1'b0, r_out_row == '0};
            r_s1_left_z  <= r_out_col == '0;
            r_s1_right_z <= last_col;
            r_s1_bank[0] <= (r_out_bank == 2'd0) ? 2'd2 : r_out_bank - 2'd1;
            r_s1_bank[1] <= r_out_bank;
            r_s1_bank[2] <= (r_out_bank == 2'd2) ? 2'd0 : r_out_bank + 2'd1;
        end
    end

    // Window assembly; the left column is the previous output's center column.
    logic [2:0][23:0] r_prev;
    logic [2:0][23:0] ctr, lft, rgt;
    t_stage           s2_in;
    t_stage           r_s2;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ctr[j] = r_s1_row_z[j] ? 24'd0 : rd_a[r_s1_bank[j]];
            rgt[j] = (r_s1_row_z[j] || r_s1_right_z) ? 24'd0 : rd_b[r_s1_bank[j]];
            lft[j] = r_s1_left_z ? 24'd0 : r_prev[j];
        end
        s2_in.valid     = r_s1_valid;
        s2_in.frame_end = r_s1_end;
        for (int ch = 0; ch < 3; ch++) begin
            s2_in.sum[ch] = '0;
            for (int j = 0; j < 3; j++) begin
                s2_in.v[ch][3 * j]     = lft[j][23 - 8 * ch -: 8];
                s2_in.v[ch][3 * j + 1] = ctr[j][23 - 8 * ch -: 8];
                s2_in.v[ch][3 * j + 2] = rgt[j][23 - 8 * ch -: 8];
            end
            for (int k = 0; k < WIN_AREA; k++) begin
                s2_in.sum[ch] = s2_in.sum[ch] + SUM_W'(s2_in.v[ch][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (en) begin
            r_s2.valid <= s2_in.valid;
        end
        if (en) begin
            r_s2.frame_end <= s2_in.frame_end;
            r_s2.sum       <= s2_in.sum;
            r_s2.v         <= s2_in.v;
        end
        if (en && r_s1_valid) begin
            r_prev <= ctr;
        end
    end

    // Sorting chain: nine alternating layers sort nine samples.
    t_stage chain [WIN_AREA+1];

    assign chain[0] = r_s2;

    for (genvar i = 0; i < WIN_AREA; i++) begin : g_cell
        wrmf_sort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_odd   (1'(i % 2)),
            .i_data  (chain[i]),
            .o_data  (chain[i + 1])
        );
    end

    // Output register.
    t_stage                    fin;
    logic [2:0][7:0]           res;
    logic [SUM_W+RECIP_W-1:0]  prod [3];

    assign fin = chain[WIN_AREA];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = (SUM_W + RECIP_W)'(fin.sum[ch]) * (SUM_W + RECIP_W)'(MEAN_RECIP);
            case (r_filter_mode)
                MODE_MEAN:   res[ch] = prod[ch][23:16];
                MODE_MEDIAN: res[ch] = fin.v[ch][(WIN_AREA - 1) / 2];
                default:     res[ch] = fin.v[ch][WIN_AREA - 1];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= fin.valid;
        end
        if (en) begin
            o_out_item.out_red   <= res[0];
            o_out_item.out_green <= res[1];
            o_out_item.out_blue  <= res[2];
            o_out_item.frame_end <= fin.frame_end;
        end
    end

    // Checks.
    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_valid) |-> $past(accept))
        else $error("window read started without an accepted item");

    a_done_parks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_in_col == '0 && r_in_row == '0))
        else $error("input position moved after the frame was complete");

    a_out_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_out_col} < w)
        else $error("output column beyond frame width");

    a_out_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_out_row} < h)
        else $error("output row beyond frame height");

endmodule

/* tb/sv/tb_window_rank_mean_filter_rgb_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the RGB 3x3 window filter unit.
// Depends on wrmf_pkg and window_rank_mean_filter_rgb_unit.
module tb_window_rank_mean_filter_rgb_unit;
    import wrmf_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE     = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    window_rank_mean_filter_rgb_unit dut (.*);

    // Shadow of the filter: geometry, mode, stored rows and positions.
    logic [23:0] row_buf [3][MAX_WIDTH];
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [1:0]  cfg_mode;
    int          px_col, px_row, res_col, res_row;
    bit          frame_in_done;
    bit          frame_closed;

    t_out_item   pending_pixels[$];
    int          error_count, pixels_sent, flushes_sent, results_seen, frames_done;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int width_eff();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int height_eff();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic logic [7:0] rank_of(input logic [7:0] s [9]);
        logic [7:0] v [9];
        logic [7:0] key;
        int sum, best, j;
        sum = 0;
        best = 0;
        for (int i = 0; i < 9; i++) begin
            v[i] = s[i];
            sum += s[i];
            if (s[i] > best) best = s[i];
        end
        if (cfg_mode == MODE_MEAN) return 8'(sum / 9);
        if (cfg_mode == MODE_MEDIAN) begin
            for (int i = 1; i < 9; i++) begin
                key = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > key) begin
                    v[j + 1] = v[j];
                    j--;
                end
                v[j + 1] = key;
            end
            return v[4];
        end
        return 8'(best);
    endfunction

    task automatic restart_frame();
        px_col = 0;
        px_row = 0;
        res_col = 0;
        res_row = 0;
        frame_in_done = 0;
    endtask

    // Advances the shadow by one accepted item; got tells whether a pixel comes out.
    task automatic filter_step(input t_in_item it, output bit got, output t_out_item res);
        int w, h, received, need, rr, cc, r, c;
        logic [23:0] px;
        logic [7:0] sr [9];
        logic [7:0] sg [9];
        logic [7:0] sb [9];
        w = width_eff();
        h = height_eff();
        got = 0;
        res = '0;
        if (!it.flush && !frame_in_done) begin
            row_buf[px_row % 3][px_col] = {it.in_red, it.in_green, it.in_blue};
            px_col++;
            if (px_col >= w) begin
                px_col = 0;
                px_row++;
                if (px_row >= h) begin
                    px_row = 0;
                    frame_in_done = 1;
                end
            end
        end
        received = frame_in_done ? w * h : px_row * w + px_col;
        rr = (res_row + 1 > h - 1) ? h - 1 : res_row + 1;
        cc = (res_col + 1 > w - 1) ? w - 1 : res_col + 1;
        need = rr * w + cc;
        if (received <= need) return;
        for (int k = 0; k < 9; k++) begin
            r = res_row + k / 3 - 1;
            c = res_col + k % 3 - 1;
            px = '0;
            if (r >= 0 && c >= 0 && r < h && c < w) px = row_buf[r % 3][c];
            sr[k] = px[23:16];
            sg[k] = px[15:8];
            sb[k] = px[7:0];
        end
        got = 1;
        res.out_red = rank_of(sr);
        res.out_green = rank_of(sg);
        res.out_blue = rank_of(sb);
        res_col++;
        if (res_col >= w) begin
            res_col = 0;
            res_row++;
            if (res_row >= h) begin
                res.frame_end = 1'b1;
                frame_closed = 1;
                restart_frame();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int seen);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, seen);
        error_count++;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        mask = (idx == REG_WIDTH) ? 32'h7ff : (idx == REG_HEIGHT) ? 32'h1fff : 32'h3;
        if ((prdata & mask) != (value & mask))
            report_mismatch($sformatf("readback of register %0d", idx), value & mask, prdata & mask);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_WIDTH: begin
                cfg_width = value[10:0];
                restart_frame();
            end
            REG_HEIGHT: begin
                cfg_height = value[12:0];
                restart_frame();
            end
            default: cfg_mode = value[1:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input int w, input int h, input int mode);
        wait_drained();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_MODE, mode);
    endtask

    // Offers one item; typed_ok selects the given expectation over the shadow's.
    task automatic send_item(input t_in_item it, input bit typed_ok, input bit typed_got,
                             input t_out_item typed_res);
        bit got;
        t_out_item res;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 17) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.flush) flushes_sent++;
        else pixels_sent++;
        filter_step(it, got, res);
        if (typed_ok) begin
            got = typed_got;
            res = typed_res;
        end
        if (got) pending_pixels.push_back(res);
    endtask

    task automatic send_shadow(input t_in_item it);
        send_item(it, 1'b0, 1'b0, '0);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic t_in_item random_pixel();
        t_in_item it;
        it = t_in_item'($urandom);
        it.flush = 1'b0;
        case ($urandom_range(9))
            0: {it.in_red, it.in_green, it.in_blue} = '1;
            1: {it.in_red, it.in_green, it.in_blue} = '0;
            default: ;
        endcase
        return it;
    endfunction

    // One frame of random content with stray flushes, then drained by flushes and extra pixels.
    // A frame that is abandoned or larger than cap pixels is cut short and left undrained.
    task automatic run_frame(input bit abandon, input int cap);
        int total, stop_at;
        bit cut;
        t_in_item it;
        total = width_eff() * height_eff();
        cut = abandon || (total > cap);
        stop_at = abandon ? $urandom_range(total) : total;
        if (stop_at > cap) stop_at = cap;
        frame_closed = 0;
        for (int n = 0; n < stop_at; n++) begin
            if ($urandom_range(99) < 5) begin
                it = t_in_item'($urandom);
                it.flush = 1'b1;
                send_shadow(it);
            end
            send_shadow(random_pixel());
        end
        while (!cut && !frame_closed) begin
            it = t_in_item'($urandom);
            // A pixel after the frame's last one only drains, like a flush.
            if ($urandom_range(3) != 0) it.flush = 1'b1;
            else it.flush = 1'b0;
            send_shadow(it);
        end
        end_burst();
    endtask

    typedef struct {
        bit        cfg;
        int        w, h, mode;
        t_in_item  it;
        bit        typed;
        bit        gives;
        t_out_item res;
    } t_directed_row;

    t_directed_row directed_rows[] = '{
        '{1, 1, 1, MODE_MAX,    '{255, 0, 170, 0}, 1, 1, '{255, 0, 170, 1}},
        '{1, 1, 1, MODE_MEAN,   '{255, 0, 170, 0}, 1, 1, '{28, 0, 18, 1}},
        '{1, 1, 1, MODE_MEDIAN, '{255, 0, 170, 0}, 1, 1, '{0, 0, 0, 1}},
        '{1, 1, 1, 3,           '{0, 255, 85, 0},  1, 1, '{0, 255, 85, 1}},
        '{1, 0, 0, MODE_MAX,    '{1, 2, 4, 0},     1, 1, '{1, 2, 4, 1}},
        '{1, 1, 1, MODE_MAX,    '{255, 255, 255, 1}, 1, 0, '{0, 0, 0, 0}},
        '{0, 1, 1, MODE_MEAN,   '{9, 18, 27, 0},   0, 0, '{0, 0, 0, 0}},
        '{1, 3, 2, MODE_MEDIAN, '{10, 200, 30, 0}, 0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{40, 50, 255, 0}, 0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{0, 90, 128, 0},  0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{77, 1, 254, 0},  0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{128, 127, 3, 0}, 0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{6, 66, 166, 0},  0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{0, 0, 0, 1},     0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{255, 0, 0, 1},   0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{0, 255, 0, 1},   0, 0, '{0, 0, 0, 0}},
        '{0, 3, 2, MODE_MEDIAN, '{0, 0, 255, 1},   0, 0, '{0, 0, 0, 0}}
    };

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                $display("unexpected output item at %0t", $realtime);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (want.out_red != o_out_item.out_red)
                    report_mismatch("red", want.out_red, o_out_item.out_red);
                if (want.out_green != o_out_item.out_green)
                    report_mismatch("green", want.out_green, o_out_item.out_green);
                if (want.out_blue != o_out_item.out_blue)
                    report_mismatch("blue", want.out_blue, o_out_item.out_blue);
                if (want.frame_end != o_out_item.frame_end)
                    report_mismatch("frame_end", want.frame_end, o_out_item.frame_end);
                if (o_out_item.frame_end) frames_done++;
            end
        end
    end

    // Output back-pressure, with one long hold once results are flowing.
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 150) begin
                held = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 17);
            end
        end
    end

    // Watchdog on cycles without any accepted input item or taken output item.
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int phase, random_pixels, start_pixels;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 0;
        error_count = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < MAX_WIDTH; c++) row_buf[r][c] = '0;
        cfg_width = 11'd1024;
        cfg_height = 13'd1;
        cfg_mode = MODE_MAX;
        restart_frame();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg) begin
                end_burst();
                configure(directed_rows[i].w, directed_rows[i].h, directed_rows[i].mode);
            end
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].gives,
                      directed_rows[i].res);
        end
        end_burst();

        // Geometry extremes, cut short: the widest row clipped from above, the tallest column.
        configure(2047, 1, MODE_MEAN);
        run_frame(0, 64);
        configure(1, 8191, MODE_MEDIAN);
        run_frame(0, 64);

        random_pixels = 0;
        phase = 0;
        while (random_pixels < 800) begin
            calm = (phase >= 4 && phase < 8);
            case ($urandom_range(9))
                0: configure($urandom_range(1, 1024), $urandom_range(1, 2), $urandom_range(3));
                1: configure(1, $urandom_range(1, 40), $urandom_range(3));
                2: configure(0, 0, $urandom_range(3));
                default: configure($urandom_range(1, 12), $urandom_range(1, 8),
                                   $urandom_range(3));
            endcase
            start_pixels = pixels_sent;
            run_frame($urandom_range(9) == 0, 256);
            random_pixels += pixels_sent - start_pixels;
            phase++;
        end
        calm = 0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0d expected output items never came", pending_pixels.size());
            error_count++;
        end
        $display("sent %0d pixels and %0d flushes over %0d random frames", pixels_sent,
                 flushes_sent, phase);
        $display("checked %0d output items, %0d frames closed, %0d errors", results_seen,
                 frames_done, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
